>>> hw/rtl/gmb_pkg.sv
package gmb_pkg;

  localparam int DEF_VERTEX_CAP = 65536;
  localparam int DEF_LOCAL_CAP  = 256;
  localparam int INQ_DEPTH      = 2;
  localparam int OUTQ_DEPTH     = 8;

  localparam logic [8:0] VLIM_RESET = 9'd64;
  localparam logic [7:0] TLIM_RESET = 8'd124;

  typedef enum logic [1:0] {
    REG_VERTEX_LIMIT   = 2'd0,
    REG_TRIANGLE_LIMIT = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_DESC     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] first_vertex;
    logic [15:0] second_vertex;
    logic [15:0] third_vertex;
    logic        last_triangle;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] global_vertex;
    logic [7:0]  local_a;
    logic [7:0]  local_b;
    logic [7:0]  local_c;
    logic [31:0] list_vertex_offset;
    logic [31:0] list_triangle_offset;
    logic [8:0]  meshlet_vertices;
    logic [7:0]  meshlet_triangles;
    logic        final_result;
  } out_item_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_DECIDE,
    ST_DESC,
    ST_WALK,
    ST_MAP_RD,
    ST_MAP_WR,
    ST_TRI
  } back_state_t;

endpackage

>>> hw/rtl/gmb_front.sv
module gmb_front #(
  parameter int VERTEX_CAP = gmb_pkg::DEF_VERTEX_CAP
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  gmb_pkg::in_item_t item,
  input  logic              hold,
  output logic              fvalid,
  output gmb_pkg::in_item_t fitem,
  input  logic              take
);
  import gmb_pkg::*;

  localparam int MAP_DEPTH = (VERTEX_CAP < 65536) ? VERTEX_CAP : 65536;
  localparam int PW        = $clog2(INQ_DEPTH);
  localparam int CW        = $clog2(INQ_DEPTH + 1);

  in_item_t       q [INQ_DEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [CW-1:0]  cnt;
  logic           acc;
  in_item_t       clamped;

  // Indices beyond the map fold onto its last entry.
  function automatic logic [15:0] clamp(input logic [15:0] v);
    if ({1'b0, v} >= 17'(MAP_DEPTH)) begin
      return 16'(MAP_DEPTH - 1);
    end
    return v;
  endfunction

  always_comb begin
    clamped               = item;
    clamped.first_vertex  = clamp(item.first_vertex);
    clamped.second_vertex = clamp(item.second_vertex);
    clamped.third_vertex  = clamp(item.third_vertex);
  end

  assign full   = hold || (cnt == CW'(INQ_DEPTH));
  assign acc    = push && !full;
  assign fvalid = (cnt != '0);
  assign fitem  = q[rp];

  always_ff @(posedge clk) begin
    if (acc) begin
      q[wp] <= clamped;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (acc) begin
        wp <= (wp == PW'(INQ_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (take) begin
        rp <= (rp == PW'(INQ_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + CW'(acc) - CW'(take);
    end
  end

endmodule

>>> hw/rtl/gmb_outq.sv
module gmb_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  gmb_pkg::out_item_t wdata,
  output logic               qfull,
  output logic               empty,
  input  logic               pop,
  output gmb_pkg::out_item_t result
);
  import gmb_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  out_item_t     q [OUTQ_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;
  logic          rd;
  logic          wen;

  assign qfull  = (cnt == CW'(OUTQ_DEPTH));
  assign empty  = (cnt == '0);
  assign rd     = pop && !empty;
  assign wen    = wr && !qfull;
  assign result = q[rp];

  always_ff @(posedge clk) begin
    if (wen) begin
      q[wp] <= wdata;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wen) begin
        wp <= (wp == PW'(OUTQ_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd) begin
        rp <= (rp == PW'(OUTQ_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + CW'(wen) - CW'(rd);
    end
  end

endmodule

>>> hw/rtl/gmb_back.sv
module gmb_back #(
  parameter int VERTEX_CAP = gmb_pkg::DEF_VERTEX_CAP,
  parameter int LOCAL_CAP  = gmb_pkg::DEF_LOCAL_CAP
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [8:0]          vertex_limit,
  input  logic [7:0]          triangle_limit,
  input  logic                fvalid,
  input  gmb_pkg::in_item_t   fitem,
  output logic                take,
  output logic                out_push,
  output gmb_pkg::out_item_t  out_item,
  input  logic                out_full,
  output gmb_pkg::back_stat_t stat
);
  import gmb_pkg::*;

  localparam int MAP_DEPTH = (VERTEX_CAP < 65536) ? VERTEX_CAP : 65536;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int LIST_AW   = $clog2(LOCAL_CAP);

  // Slot map entry: valid bit on top, local slot below.
  logic [8:0]        map_mem [MAP_DEPTH];
  logic [8:0]        map_rd;
  logic [MAP_AW-1:0] map_ra;
  logic              map_we;
  logic [MAP_AW-1:0] map_wa;
  logic [8:0]        map_wd;

  logic [MAP_AW-1:0] list_mem [LOCAL_CAP];
  logic [MAP_AW-1:0] list_rd;
  logic [LIST_AW-1:0] list_ra;
  logic              list_we;
  logic [LIST_AW-1:0] list_wa;

  back_state_t       state, state_next;
  logic [MAP_AW-1:0] g0, g1, g2, g0_next, g1_next, g2_next;
  logic              last, last_next;
  logic [1:0]        step, step_next;
  logic [1:0]        fresh, fresh_next;
  logic [7:0]        l0, l1, l2, l0_next, l1_next, l2_next;
  logic [8:0]        vcnt, vcnt_next;
  logic [7:0]        tcnt, tcnt_next;
  logic [31:0]       vbase, vbase_next;
  logic [31:0]       tbase, tbase_next;
  logic [8:0]        wi, wi_next;
  logic [MAP_AW-1:0] clr, clr_next;
  logic              closing_last, closing_last_next;
  logic [MAP_AW-1:0] gsel;
  logic [8:0]        vlim;
  logic              need_close;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rd <= map_mem[map_ra];
    if (list_we) begin
      list_mem[list_wa] <= gsel;
    end
    list_rd <= list_mem[list_ra];
  end

  always_comb begin
    case (step)
      2'd0:    gsel = g0;
      2'd1:    gsel = g1;
      default: gsel = g2;
    endcase
  end

  assign vlim = (vertex_limit > 9'(LOCAL_CAP)) ? 9'(LOCAL_CAP) : vertex_limit;
  assign need_close = ({1'b0, vcnt} + 10'(fresh) > {1'b0, vlim}) ||
                      ({1'b0, tcnt} + 9'd1 > {1'b0, triangle_limit});

  assign stat.clearing = (state == ST_CLEAR);

  always_comb begin
    state_next        = state;
    g0_next           = g0;
    g1_next           = g1;
    g2_next           = g2;
    last_next         = last;
    step_next         = step;
    fresh_next        = fresh;
    l0_next           = l0;
    l1_next           = l1;
    l2_next           = l2;
    vcnt_next         = vcnt;
    tcnt_next         = tcnt;
    vbase_next        = vbase;
    tbase_next        = tbase;
    wi_next           = wi;
    clr_next          = clr;
    closing_last_next = closing_last;
    take              = 1'b0;
    out_push          = 1'b0;
    out_item          = '0;
    map_ra            = gsel;
    map_we            = 1'b0;
    map_wa            = gsel;
    map_wd            = '0;
    list_ra           = wi[LIST_AW-1:0];
    list_we           = 1'b0;
    list_wa           = vcnt[LIST_AW-1:0];

    case (state)
      ST_CLEAR: begin
        map_we   = 1'b1;
        map_wa   = clr;
        clr_next = clr + 1'b1;
        if (clr == MAP_AW'(MAP_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (fvalid) begin
          take       = 1'b1;
          g0_next    = fitem.first_vertex[MAP_AW-1:0];
          g1_next    = fitem.second_vertex[MAP_AW-1:0];
          g2_next    = fitem.third_vertex[MAP_AW-1:0];
          last_next  = fitem.last_triangle;
          step_next  = 2'd0;
          fresh_next = 2'd0;
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        // Reads go out on steps 0..2; each registered result is counted on the step after.
        if (step != 2'd0) begin
          fresh_next = fresh + {1'b0, !map_rd[8]};
        end
        step_next = step + 2'd1;
        if (step == 2'd3) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        step_next = 2'd0;
        if (need_close && tcnt != 8'd0) begin
          closing_last_next = 1'b0;
          state_next        = ST_DESC;
        end else begin
          state_next = ST_MAP_RD;
        end
      end
      ST_DESC: begin
        out_push                      = !out_full;
        out_item.kind                 = KIND_DESC;
        out_item.list_vertex_offset   = vbase;
        out_item.list_triangle_offset = tbase;
        out_item.meshlet_vertices     = vcnt;
        out_item.meshlet_triangles    = tcnt;
        out_item.final_result         = closing_last;
        if (!out_full) begin
          wi_next    = 9'd0;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        // Unmap the closed meshlet's vertices, one list entry a cycle.
        if (wi != 9'd0) begin
          map_we = 1'b1;
          map_wa = list_rd;
        end
        wi_next = wi + 9'd1;
        if (wi == vcnt) begin
          vcnt_next = 9'd0;
          tcnt_next = 8'd0;
          step_next = 2'd0;
          if (closing_last) begin
            vbase_next = 32'd0;
            tbase_next = 32'd0;
            state_next = ST_IDLE;
          end else begin
            vbase_next = vbase + 32'(vcnt);
            tbase_next = tbase + 32'(tcnt);
            state_next = ST_MAP_RD;
          end
        end
      end
      ST_MAP_RD: begin
        state_next = ST_MAP_WR;
      end
      ST_MAP_WR: begin
        if (map_rd[8] || !out_full) begin
          if (!map_rd[8]) begin
            out_push               = 1'b1;
            out_item.kind          = KIND_VERTEX;
            out_item.global_vertex = 16'(gsel);
            map_we                 = 1'b1;
            map_wd                 = {1'b1, vcnt[7:0]};
            list_we                = 1'b1;
            vcnt_next              = vcnt + 9'd1;
          end
          case (step)
            2'd0:    l0_next = map_rd[8] ? map_rd[7:0] : vcnt[7:0];
            2'd1:    l1_next = map_rd[8] ? map_rd[7:0] : vcnt[7:0];
            default: l2_next = map_rd[8] ? map_rd[7:0] : vcnt[7:0];
          endcase
          if (step == 2'd2) begin
            state_next = ST_TRI;
          end else begin
            step_next  = step + 2'd1;
            state_next = ST_MAP_RD;
          end
        end
      end
      ST_TRI: begin
        out_push              = !out_full;
        out_item.kind         = KIND_TRIANGLE;
        out_item.local_a      = l0;
        out_item.local_b      = l1;
        out_item.local_c      = l2;
        out_item.final_result = !last;
        if (!out_full) begin
          tcnt_next = tcnt + 8'd1;
          if (last) begin
            closing_last_next = 1'b1;
            state_next        = ST_DESC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    g0    <= g0_next;
    g1    <= g1_next;
    g2    <= g2_next;
    last  <= last_next;
    l0    <= l0_next;
    l1    <= l1_next;
    l2    <= l2_next;
    fresh <= fresh_next;
    wi    <= wi_next;
    if (rst) begin
      state        <= ST_CLEAR;
      clr          <= '0;
      step         <= 2'd0;
      vcnt         <= 9'd0;
      tcnt         <= 8'd0;
      vbase        <= 32'd0;
      tbase        <= 32'd0;
      closing_last <= 1'b0;
    end else begin
      state        <= state_next;
      clr          <= clr_next;
      step         <= step_next;
      vcnt         <= vcnt_next;
      tcnt         <= tcnt_next;
      vbase        <= vbase_next;
      tbase        <= tbase_next;
      closing_last <= closing_last_next;
    end
  end

endmodule

>>> hw/rtl/greedy_meshlet_builder.sv
// Steps: the back end picks up a request, probes the slot map for its three corners, decides
// on a close, maps each corner with a read and a write, then emits the triangle entry.
// Closing a meshlet emits its descriptor, then walks its vertex list to unmap its vertices.
// A new request is taken only once the last one's results are queued. Queues on both sides
// decouple stalls. Reset (synchronous, active high) starts a pass that unmaps all
// min(VERTEX_CAP, 65536) map entries, one per cycle; full stays high until the pass is done.
module greedy_meshlet_builder #(
  parameter int VERTEX_CAP = gmb_pkg::DEF_VERTEX_CAP,
  parameter int LOCAL_CAP  = gmb_pkg::DEF_LOCAL_CAP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  gmb_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output gmb_pkg::out_item_t result,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);
  import gmb_pkg::*;

  // Configuration registers; writes must come only while the block is idle; it does not check.
  logic [8:0] vertex_limit;
  logic [7:0] triangle_limit;

  // Front queue to back end.
  logic       fvalid;
  in_item_t   fitem;
  logic       take;

  // Back end to result queue.
  logic       back_push;
  out_item_t  back_item;
  logic       outq_full;
  back_stat_t bstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_limit   <= VLIM_RESET;
      triangle_limit <= TLIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VERTEX_LIMIT:   vertex_limit   <= cfg_data;
        REG_TRIANGLE_LIMIT: triangle_limit <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // The front end clamps corner indices into the map and holds the request until
  // the back end is ready; it refuses requests while the map is being cleared.
  gmb_front #(
    .VERTEX_CAP(VERTEX_CAP)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .hold   (bstat.clearing),
    .fvalid (fvalid),
    .fitem  (fitem),
    .take   (take)
  );

  // The back end owns the slot map and the open meshlet's vertex list and emits
  // descriptors, vertex entries and triangle entries in order.
  gmb_back #(
    .VERTEX_CAP(VERTEX_CAP),
    .LOCAL_CAP (LOCAL_CAP)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .vertex_limit   (vertex_limit),
    .triangle_limit (triangle_limit),
    .fvalid         (fvalid),
    .fitem          (fitem),
    .take           (take),
    .out_push       (back_push),
    .out_item       (back_item),
    .out_full       (outq_full),
    .stat           (bstat)
  );

  // Results wait here so that a slow consumer stalls the back end only once the queue is full.
  gmb_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .wr     (back_push),
    .wdata  (back_item),
    .qfull  (outq_full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // After reset the map clear keeps the input closed.
  a_reset_blocks: assert property (@(posedge clk) rst |=> full)
    else $error("input open right after reset");

  // The back end must never push a result into a full result queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    back_push |-> !outq_full)
    else $error("result pushed into full queue");

  // No request leaves the front queue while the map is being cleared.
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    bstat.clearing |-> !take)
    else $error("request taken during map clear");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import gmb_pkg::*;

  // Index past the register file; the block must ignore writes to it.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 300;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  in_item_t   item;
  logic       empty;
  logic       pop;
  out_item_t  result;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  greedy_meshlet_builder i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mirror of the block's state. The slot map keeps a valid bit and a local slot per
  // global vertex; the vertex list remembers which entries to unmap on a close.
  bit          vert_mapped [0:65535];
  logic [7:0]  vert_slot [0:65535];
  logic [15:0] open_verts [0:255];
  int          open_vcnt;
  int          open_tcnt;
  logic [31:0] vbase;
  logic [31:0] tbase;
  logic [8:0]  vertex_limit;
  logic [7:0]  triangle_limit;

  out_item_t   pending_results [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          recv_on;

  function automatic out_item_t triangle_res(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    out_item_t r;
    r = '0;
    r.kind = KIND_TRIANGLE;
    r.local_a = a;
    r.local_b = b;
    r.local_c = c;
    r.final_result = 1'b1;
    return r;
  endfunction

  function automatic out_item_t desc_res(logic [31:0] vo, logic [31:0] to, logic [8:0] nv,
                                         logic [7:0] nt);
    out_item_t r;
    r = '0;
    r.kind = KIND_DESC;
    r.list_vertex_offset = vo;
    r.list_triangle_offset = to;
    r.meshlet_vertices = nv;
    r.meshlet_triangles = nt;
    r.final_result = 1'b1;
    return r;
  endfunction

  // Emit the open meshlet's descriptor and free its vertices. An empty meshlet is
  // never closed, which is what lets a tiny limit still take one triangle.
  function automatic void close_meshlet();
    out_item_t r;
    if (open_tcnt == 0)
      return;
    r = desc_res(vbase, tbase, open_vcnt[8:0], open_tcnt[7:0]);
    r.final_result = 1'b0;
    pending_results.insert(pending_results.size(), r);
    for (int i = 0; i < open_vcnt && i < 256; i++)
      vert_mapped[open_verts[i]] = 1'b0;
    vbase += open_vcnt;
    tbase += open_tcnt;
    open_vcnt = 0;
    open_tcnt = 0;
  endfunction

  // Works out every result one triangle request causes and queues them in order.
  function automatic void build_step(in_item_t it);
    logic [15:0] g [3];
    logic [7:0]  l [3];
    int          fresh;
    int          vlim;
    out_item_t   r;
    g[0] = it.first_vertex;
    g[1] = it.second_vertex;
    g[2] = it.third_vertex;
    fresh = 0;
    // A repeated unmapped corner counts once per corner in the limit test.
    for (int k = 0; k < 3; k++)
      if (!vert_mapped[g[k]])
        fresh++;
    vlim = (vertex_limit > 256) ? 256 : int'(vertex_limit);
    if (open_vcnt + fresh > vlim || open_tcnt + 1 > int'(triangle_limit))
      close_meshlet();
    for (int k = 0; k < 3; k++) begin
      if (!vert_mapped[g[k]]) begin
        vert_mapped[g[k]] = 1'b1;
        vert_slot[g[k]] = open_vcnt[7:0];
        if (open_vcnt < 256)
          open_verts[open_vcnt] = g[k];
        open_vcnt++;
        r = '0;
        r.kind = KIND_VERTEX;
        r.global_vertex = g[k];
        pending_results.insert(pending_results.size(), r);
      end
      l[k] = vert_slot[g[k]];
    end
    r = triangle_res(l[0], l[1], l[2]);
    r.final_result = 1'b0;
    pending_results.insert(pending_results.size(), r);
    open_tcnt++;
    // The last triangle of a mesh flushes and restarts the list offsets.
    if (it.last_triangle) begin
      close_meshlet();
      vbase = '0;
      tbase = '0;
    end
    pending_results[pending_results.size() - 1].final_result = 1'b1;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [8:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_VERTEX_LIMIT)
      vertex_limit = value;
    else if (idx == REG_TRIANGLE_LIMIT)
      triangle_limit = value[7:0];
  endtask

  // Offers one request and holds it until accepted. full comes only from registers,
  // so its value at the falling edge is the one the next rising edge sees. When a typed
  // result is given it replaces the predictor's final result of the request.
  task automatic send_triangle(in_item_t it, bit typed, out_item_t typed_res);
    bit ok;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    forever begin
      ok = !full;
      @(posedge clk);
      if (ok)
        break;
      @(negedge clk);
    end
    build_step(it);
    if (typed)
      pending_results[pending_results.size() - 1] = typed_res;
  endtask

  task automatic report(string what, out_item_t exp, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%t %s: expected %p got %p", $realtime, what, exp, got);
  endtask

  // Result side: pop decided at the falling edge, result taken at the next rising edge.
  initial begin
    bit        take;
    out_item_t got;
    out_item_t exp;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      take = recv_on && ($urandom_range(99) >= recv_stall_pct);
      pop <= take;
      if (take && !empty) begin
        got = result;
        @(posedge clk);
        if (pending_results.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          exp = pending_results.pop_front();
          if (got.kind !== exp.kind || got.global_vertex !== exp.global_vertex ||
              got.local_a !== exp.local_a || got.local_b !== exp.local_b ||
              got.local_c !== exp.local_c ||
              got.list_vertex_offset !== exp.list_vertex_offset ||
              got.list_triangle_offset !== exp.list_triangle_offset ||
              got.meshlet_vertices !== exp.meshlet_vertices ||
              got.meshlet_triangles !== exp.meshlet_triangles ||
              got.final_result !== exp.final_result)
            report("result mismatch", exp, got);
        end
      end
    end
  end

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  // Per phase: limits to program and how much each side idles.
  typedef struct {
    logic [8:0] vlim;
    logic [7:0] tlim;
    int         idle_s;
    int         idle_r;
  } phase_t;

  initial begin
    stim_row_t rows [$];
    phase_t    phases [$];
    in_item_t  it;
    logic [15:0] pool_base;
    int        n_items;

    rst = 1'b1;
    push = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = REG_VERTEX_LIMIT;
    cfg_data = '0;
    recv_on = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    open_vcnt = 0;
    open_tcnt = 0;
    vbase = '0;
    tbase = '0;
    vertex_limit = VLIM_RESET;
    triangle_limit = TLIM_RESET;
    foreach (vert_mapped[i])
      vert_mapped[i] = 1'b0;

    // Directed requests at the reset limits. The first three can be read off by hand:
    // a fresh meshlet, a triple repeat of the top index, then a flush on the last triangle.
    rows.insert(rows.size(), '{'{16'd0, 16'd1, 16'd2, 1'b0}, 1'b1, triangle_res(0, 1, 2)});
    rows.insert(rows.size(),
                '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b1, triangle_res(3, 3, 3)});
    rows.insert(rows.size(), '{'{16'd0, 16'hFFFF, 16'd1, 1'b1}, 1'b1, desc_res(0, 0, 4, 3)});
    rows.insert(rows.size(),
                '{'{16'h8000, 16'h7FFF, 16'h5555, 1'b0}, 1'b1, triangle_res(0, 1, 2)});
    rows.insert(rows.size(), '{'{16'hAAAA, 16'h8000, 16'h0001, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{16'h0001, 16'h0001, 16'h0002, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{16'hAAAA, 16'h5555, 16'h7FFF, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{16'h00FF, 16'hFF00, 16'h0F0F, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{16'hF0F0, 16'h00FF, 16'h0000, 1'b1}, 1'b0, '0});
    rows.insert(rows.size(), '{'{16'h1234, 16'h1234, 16'h1234, 1'b1}, 1'b0, '0});

    // Limits sweep the extremes: one vertex or triangle, zero, above the slot store,
    // and the largest values, plus a few in between that close meshlets often.
    phases.insert(phases.size(), '{9'd3,   8'd1,   0,  0});
    phases.insert(phases.size(), '{9'd0,   8'd0,   84, 0});
    phases.insert(phases.size(), '{9'd511, 8'd255, 0,  84});
    phases.insert(phases.size(), '{9'd256, 8'd255, 17, 17});
    phases.insert(phases.size(), '{9'd1,   8'd1,   0,  0});
    phases.insert(phases.size(), '{9'd7,   8'd4,   84, 0});
    phases.insert(phases.size(), '{9'd20,  8'd10,  0,  84});
    phases.insert(phases.size(), '{9'd12,  8'd255, 17, 17});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    recv_on = 1'b1;
    // The slot map is cleared after reset; nothing is accepted until full drops.
    @(negedge clk);
    while (full)
      @(negedge clk);

    foreach (rows[i])
      send_triangle(rows[i].it, rows[i].typed, rows[i].res);

    foreach (phases[p]) begin
      // Let the block go idle: a close walks up to the whole vertex list.
      @(negedge clk);
      push <= 1'b0;
      while (pending_results.size() != 0)
        @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
      write_reg(REG_VERTEX_LIMIT, phases[p].vlim);
      write_reg(REG_TRIANGLE_LIMIT, {1'b0, phases[p].tlim});
      write_reg(REG_UNUSED, 9'($urandom));
      send_idle_pct = phases[p].idle_s;
      recv_stall_pct = phases[p].idle_r;

      // Most requests come from a small window so that vertices are shared and the
      // limits get hit; the rest are spread over the whole index range.
      pool_base = 16'($urandom_range(0, 65535 - 40));
      n_items = 52;
      for (int n = 0; n < n_items; n++) begin
        if ($urandom_range(99) < 80) begin
          it.first_vertex = pool_base + 16'($urandom_range(0, 39));
          it.second_vertex = pool_base + 16'($urandom_range(0, 39));
          it.third_vertex = pool_base + 16'($urandom_range(0, 39));
        end else begin
          it.first_vertex = 16'($urandom);
          it.second_vertex = 16'($urandom);
          it.third_vertex = 16'($urandom);
        end
        it.last_triangle = ($urandom_range(99) < 6);
        send_triangle(it, 1'b0, '0);
      end
      // Between phases the result side drains without stalling.
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Covers the reset clear pass and the slowest mix of idling with wide margin.
  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/gmb_pkg.sv
hw/rtl/gmb_front.sv
hw/rtl/gmb_outq.sv
hw/rtl/gmb_back.sv
hw/rtl/greedy_meshlet_builder.sv
tb/tb.sv
